// ===== sv/xrg_pkg.sv =====
// Shared types, constants and helper functions of the xoshiro256** generator.
package xrg_pkg;

    // Salts XORed into the four state words while seeding.
    localparam logic [63:0] SALT [4] = '{
        64'h180e_c6d3_3cfd_0aba,
        64'hd5a6_1266_f0c9_392c,
        64'ha958_2618_e03f_c9aa,
        64'h39ab_dc45_29b1_661c
    };

    // Multiplier and shift of the seeding rule.
    localparam logic [63:0] SEED_MUL   = 64'h76e1_5d3e_fefd_cbbf;
    localparam int unsigned SEED_SHIFT = 37;

    // Output scrambler: rotl(w1 * 5, 7) * 9, with the multiplications as shift-adds.
    localparam int unsigned MUL5_SHIFT = 2;
    localparam int unsigned MUL9_SHIFT = 3;
    localparam int unsigned OUT_ROT    = 7;

    // State update shift and rotation.
    localparam int unsigned UPD_SHIFT  = 17;
    localparam int unsigned UPD_ROT    = 45;

    // Default depth of the queue between the front and back parts.
    localparam int unsigned QUEUE_DEPTH = 2;

    // Index of the last state word.
    localparam logic [1:0] LAST_WORD = 2'd3;

    // Seeding sequencer states.
    typedef enum logic [2:0] {
        SEED_IDLE,
        SEED_LOAD,
        SEED_MUL0,
        SEED_MUL1,
        SEED_MUL2,
        SEED_FIN
    } xrg_seed_state_t;

    // Write of one state word by the seeding sequencer.
    typedef struct packed {
        logic        we;
        logic [1:0]  idx;
        logic [63:0] data;
    } xrg_word_wr_t;

    // One accepted draw, as handed from the front to the back.
    typedef struct packed {
        logic [63:0]        w1;
        logic signed [31:0] range_min;
        logic signed [32:0] span;
    } xrg_job_t;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } xrg_qstat_t;

    // Rotate a 64-bit word left by a constant amount.
    function automatic logic [63:0] rotl64(input logic [63:0] v, input int unsigned k);
        return (v << k) | (v >> (64 - k));
    endfunction

endpackage

// ===== sv/xrg_ifs.sv =====
// Handshake interfaces of the request and result channels.
interface xrg_req_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] range_min;
    logic signed [31:0] range_max;

    modport source (output valid, output range_min, output range_max, input ready);
    modport sink   (input valid, input range_min, input range_max, output ready);
endinterface

interface xrg_rsp_if;
    logic               valid;
    logic               ready;
    logic [63:0]        raw_value;
    logic signed [31:0] scaled_value;

    modport source (output valid, output raw_value, output scaled_value, input ready);
    modport sink   (input valid, input raw_value, input scaled_value, output ready);
endinterface

// ===== sv/xrg_seeder.sv =====
// Sequencer that derives the four state words from the seed, one multiply a cycle.
module xrg_seeder (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [31:0]           cfg_wr_data,
    output logic                  busy,
    output xrg_pkg::xrg_word_wr_t word_wr
);

    xrg_pkg::xrg_seed_state_t state_reg, state_next;
    logic [31:0] seed_reg, seed_next;
    logic [1:0]  idx_reg, idx_next;
    logic [63:0] prev_reg, prev_next;
    logic [63:0] mul_reg, mul_next;
    logic [63:0] acc_reg, acc_next;
    logic [31:0] mul_a, mul_b;
    logic [63:0] chained_word;

    // Control registers; reset starts a seeding pass from seed zero.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg <= xrg_pkg::SEED_LOAD;
            seed_reg  <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            seed_reg  <= seed_next;
            idx_reg   <= idx_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        prev_reg <= prev_next;
        mul_reg  <= mul_next;
        acc_reg  <= acc_next;
    end

    // One 32x32 multiplier, fed with the partial products of SEED_MUL * prev.
    always_comb
    begin
        unique case (state_reg)
            xrg_pkg::SEED_MUL1:
            begin
                mul_a = prev_reg[63:32];
                mul_b = xrg_pkg::SEED_MUL[31:0];
            end
            xrg_pkg::SEED_MUL2:
            begin
                mul_a = prev_reg[31:0];
                mul_b = xrg_pkg::SEED_MUL[63:32];
            end
            default:
            begin
                mul_a = prev_reg[31:0];
                mul_b = xrg_pkg::SEED_MUL[31:0];
            end
        endcase
    end

    assign mul_next = mul_a * mul_b;

    // Next word: low 64 bits of the product, XOR the shifted word plus its index, XOR salt.
    assign chained_word = (acc_reg + {mul_reg[31:0], 32'h0})
                        ^ ((prev_reg >> xrg_pkg::SEED_SHIFT) + {62'h0, idx_reg})
                        ^ xrg_pkg::SALT[idx_reg];

    // Next state and word writes.
    always_comb
    begin
        state_next   = state_reg;
        seed_next    = seed_reg;
        idx_next     = idx_reg;
        prev_next    = prev_reg;
        acc_next     = acc_reg;
        word_wr.we   = 1'b0;
        word_wr.idx  = idx_reg;
        word_wr.data = chained_word;

        unique case (state_reg)
            xrg_pkg::SEED_IDLE:
            begin
            end
            xrg_pkg::SEED_LOAD:
            begin
                word_wr.we   = 1'b1;
                word_wr.idx  = '0;
                word_wr.data = {32'h0, seed_reg} ^ xrg_pkg::SALT[0];
                prev_next    = word_wr.data;
                idx_next     = 2'd1;
                state_next   = xrg_pkg::SEED_MUL0;
            end
            xrg_pkg::SEED_MUL0:
            begin
                state_next = xrg_pkg::SEED_MUL1;
            end
            xrg_pkg::SEED_MUL1:
            begin
                acc_next   = mul_reg;
                state_next = xrg_pkg::SEED_MUL2;
            end
            xrg_pkg::SEED_MUL2:
            begin
                acc_next   = acc_reg + {mul_reg[31:0], 32'h0};
                state_next = xrg_pkg::SEED_FIN;
            end
            xrg_pkg::SEED_FIN:
            begin
                word_wr.we = 1'b1;
                prev_next  = chained_word;
                if (idx_reg == xrg_pkg::LAST_WORD)
                begin
                    state_next = xrg_pkg::SEED_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = xrg_pkg::SEED_MUL0;
                end
            end
            default:
            begin
                state_next = xrg_pkg::SEED_IDLE;
            end
        endcase

        // A seed write restarts the pass from the first word.
        if (cfg_wr_en)
        begin
            seed_next  = cfg_wr_data;
            state_next = xrg_pkg::SEED_LOAD;
        end
    end

    assign busy = (state_reg != xrg_pkg::SEED_IDLE);

endmodule

// ===== sv/xrg_front.sv =====
// Front part: holds the generator state, accepts draws and advances the state.
module xrg_front (
    input  logic                  clk,
    input  logic                  seed_busy,
    input  xrg_pkg::xrg_word_wr_t word_wr,
    input  xrg_pkg::xrg_qstat_t   q_stat,
    xrg_req_if.sink               req,
    output logic                  push,
    output xrg_pkg::xrg_job_t     push_job
);

    logic [63:0] words_reg [4];
    logic [63:0] words_next [4];
    logic [63:0] t;
    logic [63:0] w2x, w3x;

    // Items are taken only once seeding is over and the queue has room.
    assign req.ready = !seed_busy && !q_stat.full;
    assign push      = req.valid && req.ready;

    // Classify the item: the span is carried as a 33-bit signed value.
    assign push_job.w1        = words_reg[1];
    assign push_job.range_min = req.range_min;
    assign push_job.span      = $signed({req.range_max[31], req.range_max})
                              - $signed({req.range_min[31], req.range_min});

    // xoshiro256 state update, or a word loaded by the seeding sequencer.
    always_comb
    begin
        t   = words_reg[1] << xrg_pkg::UPD_SHIFT;
        w2x = words_reg[2] ^ words_reg[0];
        w3x = words_reg[3] ^ words_reg[1];
        words_next = words_reg;
        if (push)
        begin
            words_next[0] = words_reg[0] ^ w3x;
            words_next[1] = words_reg[1] ^ w2x;
            words_next[2] = w2x ^ t;
            words_next[3] = xrg_pkg::rotl64(w3x, xrg_pkg::UPD_ROT);
        end
        if (word_wr.we)
        begin
            words_next[word_wr.idx] = word_wr.data;
        end
    end

    // State words are always loaded by the seeding pass after reset.
    always_ff @(posedge clk)
    begin
        words_reg <= words_next;
    end

endmodule

// ===== sv/xrg_queue.sv =====
// Small FIFO of accepted draws between the front and back parts.
module xrg_queue #(
    parameter int unsigned DEPTH = xrg_pkg::QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  xrg_pkg::xrg_job_t   push_job,
    input  logic                pop,
    output xrg_pkg::xrg_job_t   head_job,
    output xrg_pkg::xrg_qstat_t q_stat
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    xrg_pkg::xrg_job_t mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    assign head_job     = mem[rd_ptr_reg];
    assign q_stat.full  = (count_reg == CNT_W'(DEPTH));
    assign q_stat.empty = (count_reg == '0);

endmodule

// ===== sv/xrg_back.sv =====
// Back part: scrambles the drawn word and scales it into the range, in six stages.
module xrg_back (
    input  logic                clk,
    input  logic                rst_n,
    input  xrg_pkg::xrg_qstat_t q_stat,
    input  xrg_pkg::xrg_job_t   head_job,
    output logic                pop,
    xrg_rsp_if.source           rsp
);

    logic adv;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;

    // Stage 1: w1 * 5, span magnitude and sign.
    logic [63:0]        x1_reg;
    logic [32:0]        mag1_reg;
    logic               neg1_reg;
    logic signed [31:0] min1_reg;
    // Stage 2: raw value.
    logic [63:0]        raw2_reg;
    logic [32:0]        mag2_reg;
    logic               neg2_reg;
    logic signed [31:0] min2_reg;
    // Stage 3: partial products.
    logic [63:0]        p0_reg, p1_reg, raw3_reg;
    logic               mh3_reg, neg3_reg;
    logic signed [31:0] min3_reg;
    // Stage 4: first sum.
    logic [95:0]        s4_reg;
    logic [63:0]        raw4_reg;
    logic               mh4_reg, neg4_reg;
    logic signed [31:0] min4_reg;
    // Stage 5: upper product bits and sticky flag of the fraction.
    logic [31:0]        hi5_reg;
    logic               lonz5_reg, neg5_reg;
    logic [63:0]        raw5_reg;
    logic signed [31:0] min5_reg;
    // Stage 6: output register.
    logic [63:0]        raw6_reg;
    logic signed [31:0] scaled6_reg;

    logic [63:0] rot2;
    logic [95:0] s5;
    logic [31:0] q_bits;

    // The whole pipe moves unless a result waits at the output.
    assign adv = !v6_reg || rsp.ready;
    assign pop = adv && !q_stat.empty;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= !q_stat.empty;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    assign rot2   = xrg_pkg::rotl64(x1_reg, xrg_pkg::OUT_ROT);
    assign s5     = s4_reg + (mh4_reg ? {raw4_reg, 32'h0} : 96'h0);
    // Low 32 bits of the quotient; a negative span rounds toward minus infinity.
    assign q_bits = neg5_reg ? ~hi5_reg : hi5_reg;

    // Datapath of all stages.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x1_reg   <= head_job.w1 + (head_job.w1 << xrg_pkg::MUL5_SHIFT);
            neg1_reg <= head_job.span[32];
            mag1_reg <= head_job.span[32] ? 33'(-head_job.span) : 33'(head_job.span);
            min1_reg <= head_job.range_min;

            raw2_reg <= rot2 + (rot2 << xrg_pkg::MUL9_SHIFT);
            mag2_reg <= mag1_reg;
            neg2_reg <= neg1_reg;
            min2_reg <= min1_reg;

            p0_reg   <= raw2_reg[31:0] * mag2_reg[31:0];
            p1_reg   <= raw2_reg[63:32] * mag2_reg[31:0];
            raw3_reg <= raw2_reg;
            mh3_reg  <= mag2_reg[32];
            neg3_reg <= neg2_reg;
            min3_reg <= min2_reg;

            s4_reg   <= {32'h0, p0_reg} + {p1_reg, 32'h0};
            raw4_reg <= raw3_reg;
            mh4_reg  <= mh3_reg;
            neg4_reg <= neg3_reg;
            min4_reg <= min3_reg;

            hi5_reg   <= s5[95:64];
            lonz5_reg <= |s5[63:0];
            neg5_reg  <= neg4_reg;
            raw5_reg  <= raw4_reg;
            min5_reg  <= min4_reg;

            raw6_reg    <= raw5_reg;
            scaled6_reg <= min5_reg + $signed(q_bits)
                         + $signed({31'h0, neg5_reg && !lonz5_reg});
        end
    end

    assign rsp.valid        = v6_reg;
    assign rsp.raw_value    = raw6_reg;
    assign rsp.scaled_value = scaled6_reg;

endmodule

// ===== sv/xoshiro256ss_random_generator_core.sv =====
// An accepted draw is written into the queue, then goes through the back pipeline.
// Throughput: one draw per cycle while no seeding pass runs and the queue has room;
// the state update is XORs, shifts and a rotate. Reset, and every seed write, start
// a seeding pass (one 32x32 multiplier; states MUL0, MUL1, MUL2, FIN per derived
// word) in which no item is accepted. After reset the state is that of seed zero.
module xoshiro256ss_random_generator_core #(
    parameter int unsigned QUEUE_DEPTH = xrg_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    xrg_req_if.sink     req,
    xrg_rsp_if.source   rsp
);

    logic                  seed_busy;
    xrg_pkg::xrg_word_wr_t word_wr;
    xrg_pkg::xrg_qstat_t   q_stat;
    xrg_pkg::xrg_job_t     push_job, head_job;
    logic                  push, pop;

    // Seeding sequencer.
    xrg_seeder u_seeder (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .busy        (seed_busy),
        .word_wr     (word_wr)
    );

    // Front part with the generator state.
    xrg_front u_front (
        .clk       (clk),
        .seed_busy (seed_busy),
        .word_wr   (word_wr),
        .q_stat    (q_stat),
        .req       (req),
        .push      (push),
        .push_job  (push_job)
    );

    // Queue between the two parts.
    xrg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .q_stat   (q_stat)
    );

    // Back part with the scaling pipeline.
    xrg_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_stat   (q_stat),
        .head_job (head_job),
        .pop      (pop),
        .rsp      (rsp)
    );

    // No item may enter while the state is being reseeded.
    assert property (@(posedge clk) disable iff (!rst_n) seed_busy |-> !req.ready)
        else $error("item accepted during seeding");

    // A seed write always starts a seeding pass.
    assert property (@(posedge clk) disable iff (!rst_n) cfg_wr_en |=> seed_busy)
        else $error("seed write did not start seeding");

    // The front never pushes into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n) q_stat.full |-> !push)
        else $error("push into full queue");

    // The back never pops from an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n) q_stat.empty |-> !pop)
        else $error("pop from empty queue");

endmodule

// ===== tb/xrg_draw_checker.sv =====
// Checker for the xoshiro256** generator: predicts every draw and compares the results.
module xrg_draw_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    xrg_req_if          req,
    xrg_rsp_if          rsp,
    output int          fail_count,
    output int          draws_in_flight
);

    // Constants of the seeding rule, kept apart from the design's own copy.
    localparam logic [63:0] SEED_SALT [4] = '{
        64'h180e_c6d3_3cfd_0aba,
        64'hd5a6_1266_f0c9_392c,
        64'ha958_2618_e03f_c9aa,
        64'h39ab_dc45_29b1_661c
    };
    localparam logic [63:0] SEED_MIX_MUL   = 64'h76e1_5d3e_fefd_cbbf;
    localparam int          SEED_MIX_SHIFT = 37;

    typedef struct packed {
        logic [63:0]        raw_value;
        logic signed [31:0] scaled_value;
    } draw_result_t;

    // Model copy of the four state words, and the draws still owed by the block.
    logic [63:0]  gen_state [4];
    draw_result_t due_draws [$];

    // Rebuild the state words from a seed.
    function automatic void seed_words(input logic [31:0] seed);
        logic [63:0] prev;
        gen_state[0] = {32'd0, seed} ^ SEED_SALT[0];
        for (int i = 1; i < 4; i++)
        begin
            prev         = gen_state[i - 1];
            gen_state[i] = ((SEED_MIX_MUL * prev) ^ ((prev >> SEED_MIX_SHIFT) + 64'(i)))
                           ^ SEED_SALT[i];
        end
    endfunction

    // Produce one draw for the given range and advance the state.
    function automatic draw_result_t next_draw(input logic signed [31:0] lo,
                                               input logic signed [31:0] hi);
        draw_result_t       res;
        logic [63:0]        times5;
        logic [63:0]        turned;
        logic [63:0]        shifted_w1;
        logic signed [32:0] span;
        logic [32:0]        mag;
        logic [127:0]       prod;
        logic [63:0]        quot;

        // Scrambled output taken from word 1 before the update.
        times5        = gen_state[1] * 64'd5;
        turned        = {times5[56:0], times5[63:57]};
        res.raw_value = turned * 64'd9;

        // State update.
        shifted_w1    = gen_state[1] << 17;
        gen_state[2] ^= gen_state[0];
        gen_state[3] ^= gen_state[1];
        gen_state[1] ^= gen_state[2];
        gen_state[0] ^= gen_state[3];
        gen_state[2] ^= shifted_w1;
        gen_state[3]  = {gen_state[3][18:0], gen_state[3][63:19]};

        // Scale by the signed span; a negative span floors towards minus infinity,
        // which is a ceiling on the magnitude.
        span = {hi[31], hi} - {lo[31], lo};
        mag  = span[32] ? (~span + 33'd1) : span;
        prod = {64'd0, res.raw_value} * {95'd0, mag};
        if (!span[32])
        begin
            quot             = prod[127:64];
            res.scaled_value = lo + quot[31:0];
        end
        else
        begin
            quot             = prod[127:64] + 64'(prod[63:0] != 64'd0);
            res.scaled_value = lo - quot[31:0];
        end
        return res;
    endfunction

    // Track seeds, queue the draws as they are asked for, and check each result item.
    always @(posedge clk or negedge rst_n)
    begin
        draw_result_t due;
        if (!rst_n)
        begin
            seed_words(32'd0);
            due_draws.delete();
            fail_count      = 0;
            draws_in_flight = 0;
        end
        else
        begin
            if (cfg_wr_en)
                seed_words(cfg_wr_data);

            if (rsp.valid && rsp.ready)
            begin
                if (due_draws.size() == 0)
                begin
                    $error("unexpected result item: raw_value %h scaled_value %0d",
                           rsp.raw_value, rsp.scaled_value);
                    fail_count++;
                end
                else
                begin
                    due = due_draws.pop_front();
                    if (rsp.raw_value !== due.raw_value)
                    begin
                        $error("raw_value: expected %h, actual %h",
                               due.raw_value, rsp.raw_value);
                        fail_count++;
                    end
                    if (rsp.scaled_value !== due.scaled_value)
                    begin
                        $error("scaled_value: expected %0d, actual %0d",
                               due.scaled_value, rsp.scaled_value);
                        fail_count++;
                    end
                end
            end

            if (req.valid && req.ready)
                due_draws.push_back(next_draw(req.range_min, req.range_max));

            draws_in_flight = due_draws.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
// Top of the generator testbench: clock, reset, stimulus, idling and the final verdict.
module tb_top;

    localparam int CLK_PERIOD     = 12;
    localparam int TIMEOUT_CYCLES = 200_000;
    localparam int DRAIN_CYCLES   = 16;
    localparam int NUM_PHASES     = 7;
    localparam int DRAWS_PER_PHASE = 90;
    localparam int NUM_EDGE_DRAWS = 18;

    localparam logic signed [31:0] RANGE_LOWEST  = 32'sh8000_0000;
    localparam logic signed [31:0] RANGE_HIGHEST = 32'sh7fff_ffff;

    // Directed ranges: equal, reversed and extreme ends.
    localparam logic signed [31:0] EDGE_MIN [NUM_EDGE_DRAWS] = '{
        32'sd0, RANGE_LOWEST, RANGE_HIGHEST, RANGE_LOWEST, RANGE_HIGHEST, 32'sd0,
        32'sd1, -32'sd1, 32'sd0, RANGE_LOWEST, RANGE_HIGHEST - 32'sd1, RANGE_HIGHEST,
        -32'sd100, 32'sd100, -32'sd1, RANGE_LOWEST, 32'sd0, RANGE_HIGHEST
    };
    localparam logic signed [31:0] EDGE_MAX [NUM_EDGE_DRAWS] = '{
        32'sd0, RANGE_HIGHEST, RANGE_LOWEST, RANGE_LOWEST, RANGE_HIGHEST, 32'sd1,
        32'sd0, 32'sd0, -32'sd1, RANGE_LOWEST + 32'sd1, RANGE_HIGHEST, RANGE_HIGHEST - 32'sd1,
        32'sd100, -32'sd100, -32'sd1, 32'sd0, RANGE_HIGHEST, 32'sd0
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [31:0] cfg_wr_data;
    bit          idling_on;
    int          fail_count;
    int          draws_in_flight;

    xrg_req_if req_ch ();
    xrg_rsp_if rsp_ch ();

    xoshiro256ss_random_generator_core i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_ch),
        .rsp         (rsp_ch)
    );

    xrg_draw_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .req             (req_ch),
        .rsp             (rsp_ch),
        .fail_count      (fail_count),
        .draws_in_flight (draws_in_flight)
    );

    // Clock.
    always
    begin
        #(CLK_PERIOD / 2) clk = 1'b1;
        #(CLK_PERIOD / 2) clk = 1'b0;
    end

    // Offer one draw request, perhaps after a burst of idle cycles, and wait until it is taken.
    task automatic send_draw(input logic signed [31:0] lo, input logic signed [31:0] hi);
        int gap;
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid <= 1'b0;
            gap = $urandom_range(1, 9);
            repeat (gap) @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.range_min <= lo;
        req_ch.range_max <= hi;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    // Load a new seed once every owed result item has come back.
    // A clock edge passes first so that the count already holds the last accepted item.
    task automatic write_seed(input logic [31:0] seed);
        req_ch.valid <= 1'b0;
        @(posedge clk);
        wait (draws_in_flight == 0);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= seed;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // One random request; half the ranges are arbitrary, the rest narrow, equal, reversed or extreme.
    task automatic send_random_draw();
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        int                 kind;
        kind = $urandom_range(0, 9);
        lo   = $urandom;
        hi   = $urandom;
        if (kind == 5 || kind == 6)
            hi = lo + $urandom_range(0, 16);
        else if (kind == 7)
            hi = lo;
        else if (kind == 8)
            hi = lo - $urandom_range(1, 16);
        else if (kind == 9)
        begin
            lo = $urandom_range(0, 1) ? RANGE_LOWEST : RANGE_HIGHEST;
            hi = $urandom_range(0, 1) ? RANGE_LOWEST : -32'sd1;
            if ($urandom_range(0, 1))
                hi = ~hi;
        end
        send_draw(lo, hi);
    endtask

    // Result side: ready drops in random bursts while idling is on.
    initial
    begin
        int stall;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (idling_on && $urandom_range(0, 5) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall = $urandom_range(1, 9);
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
        end
    end

    // Stimulus: reset, directed ranges, then random phases under several seeds.
    initial
    begin
        logic [31:0] seed;
        rst_n            = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_wr_data      = 32'd0;
        req_ch.valid     = 1'b0;
        req_ch.range_min = 32'sd0;
        req_ch.range_max = 32'sd0;
        idling_on        = 1'b1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The first phase runs on the seed left by reset.
        for (int i = 0; i < NUM_EDGE_DRAWS; i++)
            send_draw(EDGE_MIN[i], EDGE_MAX[i]);

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                1: seed = 32'hffff_ffff;
                2: seed = 32'h0000_0000;
                3: seed = 32'h8000_0000;
                5: seed = 32'h0000_0001;
                default: seed = $urandom;
            endcase
            if (phase != 0)
                write_seed(seed);
            idling_on = (phase != NUM_PHASES - 1);
            for (int n = 0; n < DRAWS_PER_PHASE; n++)
                send_random_draw();
        end
        req_ch.valid <= 1'b0;

        // Let the last result items drain, then give the verdict.
        @(posedge clk);
        wait (draws_in_flight == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
